>>> rtl/core/dmf_pkg.sv
// ============================================================================
// dmf_pkg - shared types and constants of the directional mean filter
// Payload structs, controller commands, state codes, mask tap tables.
// ============================================================================
package dmf_pkg;

  // Frame store geometry
  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Field widths
  localparam int PIX_W   = 8;
  localparam int ORI_W   = 8;
  localparam int COORD_W = 8;
  localparam int DIM_W   = 9;
  localparam int DATA_W  = ORI_W + PIX_W;

  // Signed tap position: coordinate plus a small offset
  localparam int POS_W  = COORD_W + 2;
  localparam int PROD_W = COORD_W + DIM_W;

  // Masks and taps
  localparam int NUM_MASKS  = 8;
  localparam int MASK_W     = $clog2(NUM_MASKS);
  localparam int NUM_TAPS   = 9;
  localparam int TAP_W      = $clog2(NUM_TAPS);
  localparam int CNT_W      = $clog2(NUM_TAPS + 1);
  localparam int SUM_W      = $clog2(NUM_TAPS * ((1 << PIX_W) - 1) + 1);
  localparam int OFS_W      = 3;
  localparam int DIV_STEP_W = $clog2(PIX_W);

  // Configuration port
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;
  localparam int RESET_DIM  = 256;
  localparam logic REG_IDX_WIDTH  = 1'b0;
  localparam logic REG_IDX_HEIGHT = 1'b1;

  // Item kinds
  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_COMPUTE = 1'b1;

  typedef logic signed [OFS_W-1:0] ofs_t;

  typedef struct packed {
    logic             kind;
    logic [PIX_W-1:0] pixel_value;
    logic [ORI_W-1:0] orientation;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0]   filtered_value;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [DIM_W-1:0] img_w;
    logic [DIM_W-1:0] img_h;
    logic             restart;
  } cfg_t;

  typedef struct packed {
    logic             load;
    logic             start;
    logic             addr_go;
    logic             center;
    logic [TAP_W-1:0] tap_idx;
    logic             mask_latch;
    logic             div_init;
    logic             div_step;
    logic             out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic pipe_empty;
    logic out_free;
  } dp_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CENTER,
    ST_ORI_READ,
    ST_ORI_PICK,
    ST_TAPS,
    ST_DRAIN,
    ST_DIV,
    ST_FINISH
  } state_t;

  // Upper orientation bound (exclusive) of each mask, in degrees
  localparam int DIR_LIMIT [NUM_MASKS] = '{12, 34, 57, 79, 102, 124, 147, 169};

  // Row and column offsets of the nine set taps of each mask
  localparam int TAP_DY [NUM_MASKS][NUM_TAPS] = '{
    '{-1, -1, -1,  0,  0,  0,  1,  1,  1},
    '{-3, -2, -2, -1, -1,  0,  0,  1,  2},
    '{-2, -2, -2,  0,  0,  0,  2,  2,  2},
    '{-2, -2, -2,  0,  0,  0,  2,  2,  2},
    '{-2, -2, -2,  0,  0,  0,  2,  2,  2},
    '{-3, -2, -1, -1,  0,  1,  1,  2,  3},
    '{-2, -2, -2,  0,  0,  0,  2,  2,  2},
    '{-1, -1, -1,  0,  0,  0,  1,  1,  1}
  };

  localparam int TAP_DX [NUM_MASKS][NUM_TAPS] = '{
    '{-2,  0,  2, -2,  0,  2, -2,  0,  2},
    '{-2, -2,  0, -2,  0,  0,  2,  2,  2},
    '{-3, -2, -1, -1,  0,  1,  1,  2,  3},
    '{-2, -1,  0, -1,  0,  1,  0,  1,  2},
    '{-1,  0,  1, -1,  0,  1, -1,  0,  1},
    '{ 1,  1,  0,  1,  0, -1,  0, -1, -1},
    '{ 1,  2,  3, -1,  0,  1, -3, -2, -1},
    '{ 1,  2,  3, -1,  0,  1, -3, -2, -1}
  };

  function automatic ofs_t tap_dy(input logic [MASK_W-1:0] m, input logic [TAP_W-1:0] i);
    return OFS_W'(TAP_DY[m][i]);
  endfunction

  function automatic ofs_t tap_dx(input logic [MASK_W-1:0] m, input logic [TAP_W-1:0] i);
    return OFS_W'(TAP_DX[m][i]);
  endfunction

  // First mask whose bound lies above the orientation; past the last bound wraps to 0
  function automatic logic [MASK_W-1:0] pick_mask(input logic [ORI_W-1:0] o);
    logic [MASK_W-1:0] m;
    logic              found;
    m     = '0;
    found = 1'b0;
    for (int k = 0; k < NUM_MASKS; k++) begin
      if (!found && (o < ORI_W'(DIR_LIMIT[k]))) begin
        m     = MASK_W'(k);
        found = 1'b1;
      end
    end
    return m;
  endfunction

endpackage

>>> rtl/core/dmf_ram.sv
// ============================================================================
// dmf_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ============================================================================
module dmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/dmf_regs.sv
// ============================================================================
// dmf_regs - configuration registers
// APB-style write/read of frame width and height; clamped sizes out.
// ============================================================================
module dmf_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dmf_pkg::PADDR_W-1:0]   paddr,
  input  logic [dmf_pkg::PDATA_W-1:0]   pwdata,
  output logic [dmf_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output dmf_pkg::cfg_t                 cfg
);

  logic [dmf_pkg::DIM_W-1:0] width_r, width_nxt;
  logic [dmf_pkg::DIM_W-1:0] height_r, height_nxt;
  logic                      wr_en;
  logic                      reg_idx;

  // Zero acts as one, anything past the store limit acts as the limit
  function automatic logic [dmf_pkg::DIM_W-1:0] clamp_dim(input logic [dmf_pkg::DIM_W-1:0] v,
                                                          input int lim);
    logic [dmf_pkg::DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = dmf_pkg::DIM_W'(1);
    end else if (v > dmf_pkg::DIM_W'(lim)) begin
      r = dmf_pkg::DIM_W'(lim);
    end
    return r;
  endfunction

  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[dmf_pkg::PADDR_W-1];
  assign pready  = 1'b1;

  // Write decode
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (wr_en) begin
      case (reg_idx)
        dmf_pkg::REG_IDX_WIDTH:  width_nxt  = pwdata[dmf_pkg::DIM_W-1:0];
        dmf_pkg::REG_IDX_HEIGHT: height_nxt = pwdata[dmf_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= dmf_pkg::DIM_W'(dmf_pkg::RESET_DIM);
      height_r <= dmf_pkg::DIM_W'(dmf_pkg::RESET_DIM);
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      dmf_pkg::REG_IDX_WIDTH:  prdata = dmf_pkg::PDATA_W'(width_r);
      dmf_pkg::REG_IDX_HEIGHT: prdata = dmf_pkg::PDATA_W'(height_r);
      default:                 prdata = '0;
    endcase
  end

  // Any write restarts load and output positions
  assign cfg.img_w   = clamp_dim(width_r, dmf_pkg::MAX_WIDTH);
  assign cfg.img_h   = clamp_dim(height_r, dmf_pkg::MAX_HEIGHT);
  assign cfg.restart = wr_en;

endmodule

>>> rtl/core/dmf_ctrl.sv
// ============================================================================
// dmf_ctrl - filter sequencer
// Accepts transactions, steps orientation read, tap walk, divide, output.
// ============================================================================
module dmf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_kind,
  input  dmf_pkg::dp_stat_t stat,
  output logic              in_stall,
  output dmf_pkg::ctl_cmd_t cmd
);

  dmf_pkg::state_t                state_r, state_nxt;
  logic [dmf_pkg::TAP_W-1:0]      tap_cnt_r, tap_cnt_nxt;
  logic [dmf_pkg::DIV_STEP_W-1:0] div_cnt_r, div_cnt_nxt;

  assign in_stall = (state_r != dmf_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= dmf_pkg::ST_IDLE;
      tap_cnt_r <= '0;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      tap_cnt_r <= tap_cnt_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    tap_cnt_nxt = tap_cnt_r;
    div_cnt_nxt = div_cnt_r;
    cmd         = '0;
    cmd.tap_idx = tap_cnt_r;
    case (state_r)
      dmf_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_kind == dmf_pkg::KIND_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = dmf_pkg::ST_CENTER;
          end
        end
      end
      dmf_pkg::ST_CENTER: begin
        cmd.addr_go = 1'b1;
        cmd.center  = 1'b1;
        state_nxt   = dmf_pkg::ST_ORI_READ;
      end
      dmf_pkg::ST_ORI_READ: begin
        state_nxt = dmf_pkg::ST_ORI_PICK;
      end
      dmf_pkg::ST_ORI_PICK: begin
        cmd.mask_latch = 1'b1;
        tap_cnt_nxt    = '0;
        state_nxt      = dmf_pkg::ST_TAPS;
      end
      dmf_pkg::ST_TAPS: begin
        cmd.addr_go = 1'b1;
        if (tap_cnt_r == dmf_pkg::TAP_W'(dmf_pkg::NUM_TAPS - 1)) begin
          state_nxt = dmf_pkg::ST_DRAIN;
        end else begin
          tap_cnt_nxt = tap_cnt_r + 1'b1;
        end
      end
      dmf_pkg::ST_DRAIN: begin
        // wait for the last reads to land in the accumulator
        if (stat.pipe_empty) begin
          cmd.div_init = 1'b1;
          div_cnt_nxt  = '0;
          state_nxt    = dmf_pkg::ST_DIV;
        end
      end
      dmf_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt_r == dmf_pkg::DIV_STEP_W'(dmf_pkg::PIX_W - 1)) begin
          state_nxt = dmf_pkg::ST_FINISH;
        end else begin
          div_cnt_nxt = div_cnt_r + 1'b1;
        end
      end
      dmf_pkg::ST_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = dmf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dmf_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // A result never overwrites one still waiting at the output
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free)
    else $error("output register loaded while occupied");

  // No tap read may be in flight once a new transaction can be taken
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dmf_pkg::ST_IDLE) |-> stat.pipe_empty)
    else $error("tap pipeline busy in idle");
`endif

endmodule

>>> rtl/core/dmf_datapath.sv
// ============================================================================
// dmf_datapath - frame store, counters, tap address, accumulate, divide
// Holds the pixel/orientation RAM and the output register.
// ============================================================================
module dmf_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  dmf_pkg::cfg_t      cfg,
  input  dmf_pkg::ctl_cmd_t  cmd,
  input  dmf_pkg::in_item_t  in_data,
  input  logic               out_stall,
  output dmf_pkg::dp_stat_t  stat,
  output logic               out_valid,
  output dmf_pkg::out_item_t out_data
);

  localparam int ADDR_W  = dmf_pkg::ADDR_W;
  localparam int COORD_W = dmf_pkg::COORD_W;
  localparam int DIM_W   = dmf_pkg::DIM_W;
  localparam int POS_W   = dmf_pkg::POS_W;
  localparam int PROD_W  = dmf_pkg::PROD_W;
  localparam int PIX_W   = dmf_pkg::PIX_W;
  localparam int SUM_W   = dmf_pkg::SUM_W;
  localparam int CNT_W   = dmf_pkg::CNT_W;

  // Load position
  logic [ADDR_W-1:0]  load_addr_r, load_addr_nxt;
  logic [COORD_W-1:0] load_col_r, load_col_nxt;
  logic [COORD_W-1:0] load_row_r, load_row_nxt;
  // Output position
  logic [COORD_W-1:0] orow_cnt_r, orow_cnt_nxt;
  logic [COORD_W-1:0] ocol_cnt_r, ocol_cnt_nxt;
  // Pixel being filtered
  logic [COORD_W-1:0] cur_row_r, cur_col_r;
  logic               cur_last_r;
  logic [dmf_pkg::MASK_W-1:0] mask_r;
  // Tap pipeline
  logic [ADDR_W-1:0]  addr_r;
  logic               issue_r, ok_r, acc_en_r;
  logic [SUM_W-1:0]   sum_r;
  logic [CNT_W-1:0]   cnt_r;
  // Divider
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic [PIX_W-1:0]   quo_r, quo_nxt;
  // Output register
  logic               out_valid_r;
  dmf_pkg::out_item_t out_data_r;

  logic [DIM_W-1:0]          w_last, h_last;
  logic                      load_eol, load_eof;
  logic                      out_eol, out_eof;
  dmf_pkg::ofs_t             ofs_dy, ofs_dx;
  logic signed [POS_W-1:0]   dy_ext, dx_ext, rr_s, cc_s;
  logic                      tap_ok;
  logic [PROD_W-1:0]         prod, addr_sum;
  logic [CNT_W:0]            trial;
  logic [CNT_W+1:0]          diff;
  logic [dmf_pkg::DATA_W-1:0] ram_wdata, ram_rdata;

  assign w_last = cfg.img_w - DIM_W'(1);
  assign h_last = cfg.img_h - DIM_W'(1);

  // Frame store: orientation in the upper byte, pixel in the lower
  assign ram_wdata = {in_data.orientation, in_data.pixel_value};

  dmf_ram #(
    .WIDTH (dmf_pkg::DATA_W),
    .DEPTH (dmf_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (load_addr_r),
    .wdata (ram_wdata),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  // Raster position of loads, wraps after the last pixel
  assign load_eol = ({1'b0, load_col_r} == w_last);
  assign load_eof = load_eol && ({1'b0, load_row_r} == h_last);

  always_comb begin
    load_addr_nxt = load_addr_r;
    load_col_nxt  = load_col_r;
    load_row_nxt  = load_row_r;
    if (cfg.restart) begin
      load_addr_nxt = '0;
      load_col_nxt  = '0;
      load_row_nxt  = '0;
    end else if (cmd.load) begin
      if (load_eof) begin
        load_addr_nxt = '0;
        load_col_nxt  = '0;
        load_row_nxt  = '0;
      end else if (load_eol) begin
        load_addr_nxt = load_addr_r + 1'b1;
        load_col_nxt  = '0;
        load_row_nxt  = load_row_r + 1'b1;
      end else begin
        load_addr_nxt = load_addr_r + 1'b1;
        load_col_nxt  = load_col_r + 1'b1;
      end
    end
  end

  // Raster position of results
  assign out_eol = ({1'b0, ocol_cnt_r} == w_last);
  assign out_eof = out_eol && ({1'b0, orow_cnt_r} == h_last);

  always_comb begin
    orow_cnt_nxt = orow_cnt_r;
    ocol_cnt_nxt = ocol_cnt_r;
    if (cfg.restart) begin
      orow_cnt_nxt = '0;
      ocol_cnt_nxt = '0;
    end else if (cmd.start) begin
      if (out_eof) begin
        orow_cnt_nxt = '0;
        ocol_cnt_nxt = '0;
      end else if (out_eol) begin
        orow_cnt_nxt = orow_cnt_r + 1'b1;
        ocol_cnt_nxt = '0;
      end else begin
        ocol_cnt_nxt = ocol_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_addr_r <= '0;
      load_col_r  <= '0;
      load_row_r  <= '0;
      orow_cnt_r  <= '0;
      ocol_cnt_r  <= '0;
    end else begin
      load_addr_r <= load_addr_nxt;
      load_col_r  <= load_col_nxt;
      load_row_r  <= load_row_nxt;
      orow_cnt_r  <= orow_cnt_nxt;
      ocol_cnt_r  <= ocol_cnt_nxt;
    end
  end

  // Latch the pixel position and the mask of this transaction
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cur_row_r  <= orow_cnt_r;
      cur_col_r  <= ocol_cnt_r;
      cur_last_r <= out_eof;
    end
    if (cmd.mask_latch) begin
      mask_r <= dmf_pkg::pick_mask(ram_rdata[dmf_pkg::DATA_W-1:PIX_W]);
    end
  end

  // Tap address: offset, bounds check, row * width + column
  assign ofs_dy = cmd.center ? '0 : dmf_pkg::tap_dy(mask_r, cmd.tap_idx);
  assign ofs_dx = cmd.center ? '0 : dmf_pkg::tap_dx(mask_r, cmd.tap_idx);
  assign dy_ext = POS_W'(ofs_dy);
  assign dx_ext = POS_W'(ofs_dx);
  assign rr_s   = $signed({2'b00, cur_row_r}) + dy_ext;
  assign cc_s   = $signed({2'b00, cur_col_r}) + dx_ext;
  assign tap_ok = !rr_s[POS_W-1] && (rr_s[DIM_W-1:0] < cfg.img_h) &&
                  !cc_s[POS_W-1] && (cc_s[DIM_W-1:0] < cfg.img_w);
  assign prod     = PROD_W'(rr_s[COORD_W-1:0]) * PROD_W'(cfg.img_w);
  assign addr_sum = prod + PROD_W'(cc_s[COORD_W-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.addr_go) begin
      addr_r <= addr_sum[ADDR_W-1:0];
    end
    ok_r <= tap_ok;
  end

  // Read pipeline flags and accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r  <= 1'b0;
      acc_en_r <= 1'b0;
      sum_r    <= '0;
      cnt_r    <= '0;
    end else begin
      issue_r  <= cmd.addr_go && !cmd.center;
      acc_en_r <= issue_r && ok_r;
      if (cmd.start) begin
        sum_r <= '0;
        cnt_r <= '0;
      end else if (acc_en_r) begin
        sum_r <= sum_r + SUM_W'(ram_rdata[PIX_W-1:0]);
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Restoring divide, one quotient bit a step. The mean fits in a pixel,
  // so the upper sum bits start as the partial remainder.
  assign trial = {rem_r, quo_r[PIX_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, cnt_r};

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (cmd.div_init) begin
      rem_nxt = CNT_W'(sum_r[SUM_W-1:PIX_W]);
      quo_nxt = sum_r[PIX_W-1:0];
    end else if (cmd.div_step) begin
      if (!diff[CNT_W+1]) begin
        rem_nxt = diff[CNT_W-1:0];
        quo_nxt = {quo_r[PIX_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[CNT_W-1:0];
        quo_nxt = {quo_r[PIX_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.filtered_value <= quo_r;
      out_data_r.out_row        <= cur_row_r;
      out_data_r.out_col        <= cur_col_r;
      out_data_r.last           <= cur_last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;
  assign stat.out_free   = !out_valid_r || !out_stall;
  assign stat.pipe_empty = !issue_r && !acc_en_r;

`ifndef NO_ASSERTIONS
  // The center tap is always in bounds, so the divisor is never zero
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_init |-> (cnt_r != '0))
    else $error("divide started with zero tap count");

  // Quotient must fit in a pixel for the shortened divide to be exact
  a_quo_fits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_init |-> (CNT_W'(sum_r[SUM_W-1:PIX_W]) < cnt_r))
    else $error("masked sum exceeds pixel range times tap count");
`endif

endmodule

>>> rtl/core/directional_mean_filter.sv
// ============================================================================
// directional_mean_filter - 8-orientation directional mean filter
// Frame load in raster order, then masked truncated mean per output pixel.
// ============================================================================
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_stall   in_item_t  (kind, pixel, orientation)
//  out      output     out_valid / out_stall out_item_t (value, row, col, last)
//  cfg      input      psel/penable/pwrite   width @ 0x0, height @ 0x4
//
//  Load transactions stream back to back.
//  A compute transaction runs a center read for the orientation,
//  nine tap reads through the single frame store read port, pipeline
//  drain, and an 8-step restoring divide.
//  Reset (rst_n low, synchronous) sets width and height to 256 and all
//  positions to pixel 0; the frame store is not cleared.
//  A result waiting on out_stall holds in the output register while loads
//  continue; the next compute waits at its end until that register frees.
//
module directional_mean_filter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  dmf_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output dmf_pkg::out_item_t            out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dmf_pkg::PADDR_W-1:0]   paddr,
  input  logic [dmf_pkg::PDATA_W-1:0]   pwdata,
  output logic [dmf_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  dmf_pkg::cfg_t     cfg;
  dmf_pkg::ctl_cmd_t cmd;
  dmf_pkg::dp_stat_t stat;

  // Configuration registers
  dmf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer
  dmf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // Frame store and arithmetic
  dmf_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

>>> bench/tb_top.sv
// ============================================================================
// tb_top - testbench of the directional mean filter
// Loads frames pixel by pixel and requests filtered pixels. A behavioral
// copy of the filter (frame store, orientation store, positions and frame
// size) predicts each result, and a checker compares every result
// transaction with the oldest prediction. Both channels idle and stall at
// random, and frame sizes run from 1x1 up to the 256x256 maximum.
// ============================================================================
`timescale 1ns / 100ps

module tb_top;

  localparam int CLK_HALF    = 6;
  localparam int RESET_LEN   = 9;
  localparam int DRAIN_WAIT  = 40;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;
  localparam int MAX_GAP     = 20;

  localparam logic [dmf_pkg::PADDR_W-1:0] ADDR_IMG_W = {1'b0, dmf_pkg::REG_IDX_WIDTH, 2'b00};
  localparam logic [dmf_pkg::PADDR_W-1:0] ADDR_IMG_H = {1'b0, dmf_pkg::REG_IDX_HEIGHT, 2'b00};

  // DUT connections
  logic                        clk;
  logic                        rst_n     = 1'b0;
  logic                        in_valid  = 1'b0;
  logic                        in_stall;
  dmf_pkg::in_item_t           in_data   = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  dmf_pkg::out_item_t          out_data;
  logic                        psel      = 1'b0;
  logic                        penable   = 1'b0;
  logic                        pwrite    = 1'b0;
  logic [dmf_pkg::PADDR_W-1:0] paddr     = '0;
  logic [dmf_pkg::PDATA_W-1:0] pwdata    = '0;
  logic [dmf_pkg::PDATA_W-1:0] prdata;
  logic                        pready;

  directional_mean_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Clock
  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  // Filter model state
  logic [dmf_pkg::PIX_W-1:0] pix_mem [dmf_pkg::STORE_DEPTH];
  logic [dmf_pkg::ORI_W-1:0] ori_mem [dmf_pkg::STORE_DEPTH];
  bit               written_map [dmf_pkg::STORE_DEPTH];
  int unsigned      img_w_reg = dmf_pkg::RESET_DIM;
  int unsigned      img_h_reg = dmf_pkg::RESET_DIM;
  int unsigned      load_pos  = 0;
  int unsigned      row_pos   = 0;
  int unsigned      col_pos   = 0;

  dmf_pkg::out_item_t pending_pixels [$];

  // Run control and statistics
  int  snd_idle_pct = 0;
  int  rcv_idle_pct = 0;
  logic hold_start  = 1'b0;
  int  hold_left    = 0;
  int  cycle_count  = 0;
  int  n_loads      = 0;
  int  n_computes   = 0;
  int  n_results    = 0;
  int  n_reg_writes = 0;
  int  n_errors     = 0;

  // --------------------------------------------------------------------------
  // Filter model
  // --------------------------------------------------------------------------
  function automatic int clamp_size(input int unsigned v, input int lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic int eff_width();
    return clamp_size(img_w_reg, dmf_pkg::MAX_WIDTH);
  endfunction

  function automatic int eff_height();
    return clamp_size(img_h_reg, dmf_pkg::MAX_HEIGHT);
  endfunction

  // Exclusive upper orientation bound of each mask
  function automatic int mask_bound(input int k);
    case (k)
      0:       return 12;
      1:       return 34;
      2:       return 57;
      3:       return 79;
      4:       return 102;
      5:       return 124;
      6:       return 147;
      default: return 169;
    endcase
  endfunction

  function automatic int mask_of(input logic [dmf_pkg::ORI_W-1:0] ori);
    for (int k = 0; k < dmf_pkg::NUM_MASKS; k++)
      if (ori < mask_bound(k)) return k;
    return 0;  // 169 and above wrap to the first mask
  endfunction

  // Half sizes and weight rows; row 0 sits in the low 7 bits, bit c of a
  // row is the weight at column offset c - half_x
  function automatic void mask_shape(input int sel, output int half_x, output int half_y,
                                     output logic [48:0] rows);
    case (sel)
      0: begin half_x = 2; half_y = 1;
        rows = {7'h00, 7'h00, 7'h00, 7'h00, 7'h15, 7'h15, 7'h15}; end
      1: begin half_x = 2; half_y = 3;  // six-row mask, row 6 unused
        rows = {7'h00, 7'h10, 7'h10, 7'h14, 7'h05, 7'h05, 7'h01}; end
      2: begin half_x = 3; half_y = 2;
        rows = {7'h00, 7'h00, 7'h70, 7'h00, 7'h1C, 7'h00, 7'h07}; end
      3: begin half_x = 2; half_y = 2;
        rows = {7'h00, 7'h00, 7'h1C, 7'h00, 7'h0E, 7'h00, 7'h07}; end
      4: begin half_x = 1; half_y = 2;
        rows = {7'h00, 7'h00, 7'h07, 7'h00, 7'h07, 7'h00, 7'h07}; end
      5: begin half_x = 1; half_y = 3;
        rows = {7'h01, 7'h01, 7'h03, 7'h02, 7'h06, 7'h04, 7'h04}; end
      6: begin half_x = 3; half_y = 2;
        rows = {7'h00, 7'h00, 7'h07, 7'h00, 7'h1C, 7'h00, 7'h70}; end
      default: begin half_x = 3; half_y = 1;
        rows = {7'h00, 7'h00, 7'h00, 7'h00, 7'h07, 7'h1C, 7'h70}; end
    endcase
  endfunction

  // Masked truncated mean at (r, c); returns 0 if any pixel it would
  // read has not been loaded yet
  function automatic bit window_mean(input int r, input int c,
                                     output logic [dmf_pkg::PIX_W-1:0] mean);
    int          w, h, hx, hy, rr, cc, sel, addr;
    int unsigned sum, cnt;
    logic [48:0] rows;
    logic [6:0]  row_bits;
    w    = eff_width();
    h    = eff_height();
    mean = '0;
    sum  = 0;
    cnt  = 0;
    addr = r * w + c;
    if (!written_map[addr]) return 1'b0;
    sel = mask_of(ori_mem[addr]);
    mask_shape(sel, hx, hy, rows);
    for (int k = -hy; k <= hy; k++) begin
      rr = r + k;
      if (rr < 0 || rr >= h) continue;
      row_bits = rows[(k + hy) * 7 +: 7];
      for (int l = -hx; l <= hx; l++) begin
        cc = c + l;
        if (cc < 0 || cc >= w || !row_bits[l + hx]) continue;
        addr = rr * w + cc;
        if (!written_map[addr]) return 1'b0;
        sum += pix_mem[addr];
        cnt++;
      end
    end
    if (cnt == 0) cnt = 1;
    mean = dmf_pkg::PIX_W'(sum / cnt);
    return 1'b1;
  endfunction

  function automatic void next_out_pos(output int r, output int c);
    r = row_pos;
    c = col_pos;
    if (r >= eff_height() || c >= eff_width()) begin
      r = 0;
      c = 0;
    end
  endfunction

  // True when the next filtered pixel reads only loaded pixels
  function automatic bit compute_ready();
    int                        r, c;
    logic [dmf_pkg::PIX_W-1:0] dummy;
    next_out_pos(r, c);
    return window_mean(r, c, dummy);
  endfunction

  // Apply one accepted input transaction to the model
  function automatic void filter_model_step(input dmf_pkg::in_item_t item);
    int                        w, h, p, r, c;
    logic [dmf_pkg::PIX_W-1:0] mean;
    dmf_pkg::out_item_t        res;
    w = eff_width();
    h = eff_height();
    if (item.kind == dmf_pkg::KIND_LOAD) begin
      p = load_pos;
      if (p >= w * h) p = 0;
      pix_mem[p]     = item.pixel_value;
      ori_mem[p]     = item.orientation;
      written_map[p] = 1'b1;
      p++;
      load_pos = (p >= w * h) ? 0 : p;
      n_loads++;
    end else begin
      next_out_pos(r, c);
      void'(window_mean(r, c, mean));
      res.filtered_value = mean;
      res.out_row        = dmf_pkg::COORD_W'(r);
      res.out_col        = dmf_pkg::COORD_W'(c);
      res.last           = (r == h - 1) && (c == w - 1);
      pending_pixels.push_back(res);
      c++;
      if (c >= w) begin
        c = 0;
        r++;
      end
      if (r >= h) r = 0;
      row_pos = r;
      col_pos = c;
      n_computes++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic send_item(input dmf_pkg::in_item_t item);
    int gap;
    gap = 0;
    while ($urandom_range(99) < snd_idle_pct && gap < MAX_GAP) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    filter_model_step(item);
  endtask

  task automatic send_load(input int pix, input int ori);
    dmf_pkg::in_item_t item;
    item.kind        = dmf_pkg::KIND_LOAD;
    item.pixel_value = dmf_pkg::PIX_W'(pix);
    item.orientation = dmf_pkg::ORI_W'(ori);
    send_item(item);
  endtask

  task automatic send_compute();
    dmf_pkg::in_item_t item;
    item.kind        = dmf_pkg::KIND_COMPUTE;
    item.pixel_value = dmf_pkg::PIX_W'($urandom);  // ignored by the block
    item.orientation = dmf_pkg::ORI_W'($urandom);
    send_item(item);
  endtask

  // Stop offering, wait for every pending result, then let loads settle
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [dmf_pkg::PADDR_W-1:0] addr, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= dmf_pkg::PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // any write restarts load and output positions
    if (addr == ADDR_IMG_W) img_w_reg = value & 'h1FF;
    else                    img_h_reg = value & 'h1FF;
    load_pos = 0;
    row_pos  = 0;
    col_pos  = 0;
    n_reg_writes++;
    @(posedge clk);
  endtask

  task automatic set_frame(input int unsigned w_raw, input int unsigned h_raw);
    settle_block();
    write_reg(ADDR_IMG_W, w_raw);
    write_reg(ADDR_IMG_H, h_raw);
  endtask

  function automatic int rand_pixel();
    case ($urandom_range(4))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(255);
    endcase
  endfunction

  // A quarter of the orientations land at or just below a mask bound
  function automatic int rand_orientation();
    case ($urandom_range(3))
      0:       return mask_bound($urandom_range(7)) - $urandom_range(1);
      1:       return ($urandom_range(1) == 0) ? 0 : 255;
      default: return $urandom_range(255);
    endcase
  endfunction

  function automatic int unsigned rand_size();
    case ($urandom_range(9))
      0:       return 0;
      1:       return $urandom_range(20, 64);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  // Mixed loads and requests; a request goes out only once its window is loaded
  task automatic run_phase(input int unsigned w_raw, input int unsigned h_raw, input int n);
    set_frame(w_raw, h_raw);
    repeat (n) begin
      if ($urandom_range(99) < 45 && compute_ready()) send_compute();
      else send_load(rand_pixel(), rand_orientation());
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checking and receiver stalls
  // --------------------------------------------------------------------------
  task automatic note_mismatch(input string msg);
    n_errors++;
    if (n_errors <= MAX_REPORTS) $display("tb_top: error: %s", msg);
  endtask

  task automatic check_result(input dmf_pkg::out_item_t act);
    dmf_pkg::out_item_t exp;
    n_results++;
    if (pending_pixels.size() == 0) begin
      note_mismatch($sformatf("unexpected result val %0d row %0d col %0d last %0b",
                              act.filtered_value, act.out_row, act.out_col, act.last));
    end else begin
      exp = pending_pixels.pop_front();
      if (act.filtered_value !== exp.filtered_value || act.out_row !== exp.out_row ||
          act.out_col !== exp.out_col || act.last !== exp.last)
        note_mismatch($sformatf(
          "result %0d: exp val %0d row %0d col %0d last %0b, got val %0d row %0d col %0d last %0b",
          n_results, exp.filtered_value, exp.out_row, exp.out_col, exp.last,
          act.filtered_value, act.out_row, act.out_col, act.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result(out_data);
    if (hold_start) begin
      hold_left  = LONG_HOLD;
      hold_start <= 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset size 256x256: the tilted mask at the corner reads only row 0
  task automatic test_reset_defaults();
    send_load(200, 150);
    send_load(55, 0);
    send_compute();
  endtask

  // 3x3 frame: first orientation of every mask, a load past the frame end,
  // and one request past the last pixel
  task automatic test_small_frame();
    set_frame(3, 3);
    send_load(255, 0);
    send_load(0, 12);
    send_load(200, 34);
    send_load(17, 57);
    send_load(255, 79);
    send_load(128, 102);
    send_load(1, 124);
    send_load(99, 147);
    send_load(255, 169);
    send_load(0, 255);       // wraps onto pixel 0
    repeat (10) send_compute();
  endtask

  // Zero sizes act as one: a 1x1 frame where every pixel is last
  task automatic test_dimension_clamp();
    set_frame(0, 0);
    send_load(77, 200);
    repeat (2) send_compute();
  endtask

  task automatic test_random_traffic();
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0:       begin snd_idle_pct = 27; rcv_idle_pct = 46; end
        1:       begin snd_idle_pct = 46; rcv_idle_pct = 27; end
        default: begin snd_idle_pct = 0;  rcv_idle_pct = 0;  end
      endcase
      repeat (3) run_phase(rand_size(), rand_size(), 70);
      case (mode)
        0:       run_phase(511, 1, 110);   // oversize width clamps to 256
        1:       run_phase(1, 511, 90);    // oversize height clamps to 256
        default: run_phase(256, 256, 90);
      endcase
    end
  endtask

  // Receiver holds off while requests keep coming, so the block backs up
  task automatic test_backpressure();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    set_frame(8, 4);
    for (int i = 0; i < 32; i++) send_load(rand_pixel(), rand_orientation());
    hold_start <= 1'b1;
    repeat (12) send_compute();
    settle_block();
    repeat (10) begin
      if ($urandom_range(1) == 0) send_compute();
      else send_load(rand_pixel(), rand_orientation());
    end
  endtask

  initial begin
    repeat (RESET_LEN) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_small_frame();
    test_dimension_clamp();
    test_random_traffic();
    test_backpressure();

    settle_block();
    $display("tb_top: %0d pixel loads, %0d filter requests, %0d register writes",
             n_loads, n_computes, n_reg_writes);
    $display("tb_top: %0d results checked, %0d mismatches, %0d still pending",
             n_results, n_errors, pending_pixels.size());
    if (n_errors == 0 && pending_pixels.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/dmf_pkg.sv
rtl/core/dmf_ram.sv
rtl/core/dmf_regs.sv
rtl/core/dmf_ctrl.sv
rtl/core/dmf_datapath.sv
rtl/core/directional_mean_filter.sv
bench/tb_top.sv
